FILE: rtl/bfp_pkg.sv
// Shared types and codes for the bit field packer and unpacker.
package bfp_pkg;

   typedef enum logic [1:0] {
      REQ_WR_FIELD = 2'd0,
      REQ_WR_BIT   = 2'd1,
      REQ_RD_FIELD = 2'd2,
      REQ_RD_BIT   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_WR_RD,
      S_WR,
      S_RD,
      S_RD_WAIT,
      S_FIN
   } state_type;

   typedef struct packed {
      logic load_req;
      logic eval;
      logic rd_old;
      logic rd_issue;
      logic wr_byte;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic ovf;
      logic is_write;
      logic last_k;
      logic rsp_free;
   } sts_type;

   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned BIT_IDX_MAX = 7;
   localparam int unsigned VALUE_BITS = 16;

endpackage

FILE: rtl/bfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/bfp_ctrl.sv
// Controller state machine that sequences the byte accesses of one request.
module bfp_ctrl
   import bfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            priority if (sts.ovf) begin
               state_in = S_FIN;
            end else if (sts.is_write) begin
               state_in = S_WR_RD;
            end else begin
               state_in = S_RD;
            end
         end
         S_WR_RD: state_in = S_WR;
         S_WR: begin
            if (sts.last_k) begin
               state_in = S_FIN;
            end
         end
         S_RD: begin
            if (sts.last_k) begin
               state_in = S_RD_WAIT;
            end
         end
         S_RD_WAIT: state_in = S_FIN;
         S_FIN: begin
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         S_EVAL:    cmd.eval     = 1'b1;
         S_WR_RD:   cmd.rd_old   = 1'b1;
         S_WR:      cmd.wr_byte  = 1'b1;
         S_RD:      cmd.rd_issue = 1'b1;
         S_RD_WAIT: cmd          = '0;
         S_FIN:     cmd.finish   = sts.rsp_free;
         default:   cmd          = '0;
      endcase
   end

endmodule

FILE: rtl/bfp_datapath.sv
// Datapath: cursors, field width, bit window, store access and result register.
module bfp_datapath
   import bfp_pkg::*;
#(
   parameter int unsigned STORE_BYTES    = 1024,
   parameter int unsigned MAX_FIELD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [15:0]                    csr_wr_data,
   input  logic [15:0]                    req_tdata,
   input  logic [1:0]                     req_tuser,
   input  cmd_type                        cmd,
   output sts_type                        sts,
   output logic                           ram_we,
   output logic [$clog2(STORE_BYTES)-1:0] ram_waddr,
   output logic [7:0]                     ram_wdata,
   output logic                           ram_re,
   output logic [$clog2(STORE_BYTES)-1:0] ram_raddr,
   input  logic [7:0]                     ram_rdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,
   output logic [0:0]                     rsp_tuser
);

   localparam int unsigned TOTAL_BITS = STORE_BYTES * BYTE_BITS;
   localparam int unsigned CUR_W      = $clog2(TOTAL_BITS + 1);
   localparam int unsigned ADDR_W     = $clog2(STORE_BYTES);
   localparam int unsigned WW         = $clog2(MAX_FIELD_BITS + 1);
   localparam int unsigned WIN_BYTES  = (MAX_FIELD_BITS + 2 * BIT_IDX_MAX) / BYTE_BITS;
   localparam int unsigned WIN_BITS   = WIN_BYTES * BYTE_BITS;
   localparam int unsigned KW         = $clog2(WIN_BYTES + 1);
   localparam int unsigned SH_W       = $clog2(WIN_BITS + 1);

   logic [CUR_W-1:0]          wcur_ff, wcur_in;
   logic [CUR_W-1:0]          rcur_ff, rcur_in;
   logic [WW-1:0]             width_ff, width_in;
   req_kind_type              kind_ff, kind_in;
   logic [15:0]               value_ff, value_in;
   logic [WIN_BITS-1:0]       win_ff, win_in;
   logic [KW-1:0]             k_ff, k_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               rsp_value_ff, rsp_value_in;
   logic                      rsp_status_ff, rsp_status_in;

   logic [4:0]                bitlen;
   logic                      is_write;
   logic                      is_field;
   logic [WW-1:0]             w;
   logic [CUR_W-1:0]          cur;
   logic                      ovf;
   logic [2:0]                offs;
   logic [ADDR_W-1:0]         idx;
   logic [SH_W-1:0]           span;
   logic [KW-1:0]             nbytes_m1;
   logic [SH_W-1:0]           sh;
   logic [MAX_FIELD_BITS-1:0] fmask;
   logic [MAX_FIELD_BITS-1:0] fval;
   logic [WIN_BITS-1:0]       wwin;
   logic [WIN_BITS-1:0]       rd_field;
   logic [7:0]                wr_slot;
   logic [7:0]                lead_mask;
   logic [KW-1:0]             cap_k;
   logic [ADDR_W-1:0]         cap_addr;
   logic [CUR_W-4:0]          wbyte;
   logic [7:0]                cap_mask;

   // Field width is the bit length of the written maximum value, at least 1 and at most MAX_FIELD_BITS.
   always_comb begin
      bitlen = 5'd0;
      for (int i = 0; i < 16; i++) begin
         if (csr_wr_data[i]) begin
            bitlen = 5'(i + 1);
         end
      end
      if (bitlen == 5'd0) begin
         bitlen = 5'd1;
      end
      if (int'(bitlen) > MAX_FIELD_BITS) begin
         bitlen = 5'(MAX_FIELD_BITS);
      end
   end

   assign width_in = csr_wr_en ? WW'(bitlen) : width_ff;

   assign is_write  = (kind_ff == REQ_WR_FIELD) || (kind_ff == REQ_WR_BIT);
   assign is_field  = (kind_ff == REQ_WR_FIELD) || (kind_ff == REQ_RD_FIELD);
   assign w         = is_field ? width_ff : WW'(1);
   assign cur       = is_write ? wcur_ff : rcur_ff;
   assign ovf       = ({1'b0, cur} + (CUR_W + 1)'(w)) > (CUR_W + 1)'(TOTAL_BITS);
   assign offs      = cur[2:0];
   assign idx       = cur[ADDR_W+2:3];
   assign span      = SH_W'(offs) + SH_W'(w) - SH_W'(1);
   assign nbytes_m1 = KW'(span >> 3);
   assign sh        = SH_W'(WIN_BITS) - SH_W'(offs) - SH_W'(w);
   assign fmask     = {MAX_FIELD_BITS{1'b1}} >> (SH_W'(MAX_FIELD_BITS) - SH_W'(w));
   assign fval      = MAX_FIELD_BITS'(value_ff) & fmask;
   assign wwin      = WIN_BITS'(fval) << sh;
   assign rd_field  = (win_ff >> sh) & WIN_BITS'(fmask);
   assign lead_mask = ~(8'hFF >> offs);

   always_comb begin
      wr_slot = 8'd0;
      for (int s = 0; s < WIN_BYTES; s++) begin
         if (k_ff == KW'(s)) begin
            wr_slot = win_ff[WIN_BITS-1-BYTE_BITS*s -: 8];
         end
      end
   end

   // Bits at or past the write cursor were never written and read as zero.
   assign cap_k    = k_ff - KW'(1);
   assign cap_addr = idx + ADDR_W'(cap_k);
   assign wbyte    = wcur_ff[CUR_W-1:3];

   always_comb begin
      priority if ((CUR_W - 3)'(cap_addr) < wbyte) begin
         cap_mask = 8'hFF;
      end else if ((CUR_W - 3)'(cap_addr) == wbyte) begin
         cap_mask = ~(8'hFF >> wcur_ff[2:0]);
      end else begin
         cap_mask = 8'h00;
      end
   end

   always_comb begin
      win_in = win_ff;
      priority if (cmd.load_req) begin
         win_in = '0;
      end else if (cmd.eval && is_write) begin
         win_in = wwin;
      end else if (rd_pend_ff) begin
         for (int s = 0; s < WIN_BYTES; s++) begin
            if (cap_k == KW'(s)) begin
               win_in[WIN_BITS-1-BYTE_BITS*s -: 8] = ram_rdata & cap_mask;
            end
         end
      end else begin
         win_in = win_ff;
      end
   end

   assign kind_in    = cmd.load_req ? req_kind_type'(req_tuser) : kind_ff;
   assign value_in   = cmd.load_req ? req_tdata : value_ff;
   assign rd_pend_in = cmd.rd_issue;

   always_comb begin
      priority if (cmd.load_req) begin
         k_in = '0;
      end else if (cmd.rd_issue || cmd.wr_byte) begin
         k_in = k_ff + KW'(1);
      end else begin
         k_in = k_ff;
      end
   end

   always_comb begin
      wcur_in = wcur_ff;
      rcur_in = rcur_ff;
      if (cmd.finish && !ovf) begin
         if (is_write) begin
            wcur_in = CUR_W'(wcur_ff + CUR_W'(w));
         end else begin
            rcur_in = CUR_W'(rcur_ff + CUR_W'(w));
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      priority if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = (!is_write && !ovf) ? VALUE_BITS'(rd_field) : 16'd0;
         rsp_status_in = ovf;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcur_ff      <= '0;
         rcur_ff      <= '0;
         width_ff     <= WW'(1);
         k_ff         <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wcur_ff      <= wcur_in;
         rcur_ff      <= rcur_in;
         width_ff     <= width_in;
         k_ff         <= k_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      win_ff        <= win_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign ram_re    = cmd.rd_old || cmd.rd_issue;
   assign ram_raddr = idx + ADDR_W'(k_ff);
   assign ram_we    = cmd.wr_byte;
   assign ram_waddr = idx + ADDR_W'(k_ff);
   assign ram_wdata = (k_ff == '0) ? ((ram_rdata & lead_mask) | wr_slot) : wr_slot;

   assign sts.ovf      = ovf;
   assign sts.is_write = is_write;
   assign sts.last_k   = (k_ff == nbytes_m1);
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_status_ff;

endmodule

FILE: rtl/bit_field_packer_unpacker.sv
// Top level of the MSB-first bit field packer and unpacker.
// Each request word on the req channel writes a field, writes one bit, reads a
// field or reads one bit; every request returns exactly one word on the rsp
// channel. Fields are packed most significant bit first into a byte store,
// with separate write and read bit cursors. The field width is the bit length
// of the field limit register, written through csr_wr_en and csr_wr_data.
// A request that would run past the end of the store changes nothing and
// returns status 1 with a zero value.
// One request is processed at a time. An in-range request passes through
// evaluation, its byte accesses and completion before its response word shows;
// a field covers one to three bytes, and the store has a single byte-wide
// port and is touched one byte per cycle. The next request can be accepted in
// the cycle in which the response word of the last one first shows.
// A rejected request goes from evaluation straight to completion.
// The response sits in an output register, so a stalled receiver holds only
// that word; a new request is accepted meanwhile and waits at completion.
// Reset clears the cursors and sets the width to 1. The store itself is not
// swept: bits at or beyond the write cursor always read as zero.
module bit_field_packer_unpacker
   import bfp_pkg::*;
#(
   parameter int unsigned STORE_BYTES    = 1024,
   parameter int unsigned MAX_FIELD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,  // field_limit
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // write_value
   input  logic [1:0]  req_tuser,    // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // read_value
   output logic [0:0]  rsp_tuser     // status
);

   localparam int unsigned ADDR_W = $clog2(STORE_BYTES);

   cmd_type           cmd;
   sts_type           sts;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   bfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bfp_datapath #(
      .STORE_BYTES    (STORE_BYTES),
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cmd         (cmd),
      .sts         (sts),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   bfp_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

FILE: rtl/bfp_checker.sv
// Port-level checker for the bit field packer and unpacker, with its bind.
module bfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   logic [1:0] pend_ff;
   logic [1:0] pend_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response word valid right after reset");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pend_ff != 2'd0))
      else $error("response word without an outstanding request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests outstanding");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 16'd0))
      else $error("rejected request returned a nonzero value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled response word changed");

endmodule

bind bit_field_packer_unpacker bfp_checker u_checker (.*);

FILE: test/bfp_response_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares every response word of the bit field packer and unpacker.
module bfp_response_checker
   import bfp_pkg::*;
#(
   parameter int unsigned STORE_BYTES    = 1024,
   parameter int unsigned MAX_FIELD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [15:0] read_value;
      logic        status;
   } rsp_word_type;

   logic [7:0]   byte_mem [STORE_BYTES];
   int unsigned  wr_pos;
   int unsigned  rd_pos;
   logic [15:0]  field_limit;
   int           errors;
   rsp_word_type due_responses [$];

   function automatic int unsigned field_bits(input logic [15:0] limit);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 16; i++) begin
         if (limit[i]) n = i + 1;
      end
      if (n == 0) n = 1;
      if (n > MAX_FIELD_BITS) n = MAX_FIELD_BITS;
      return n;
   endfunction

   function automatic rsp_word_type apply_request(input req_kind_type kind,
                                                  input logic [15:0] value);
      rsp_word_type outcome;
      int unsigned  width;
      int unsigned  pos;
      int unsigned  p;
      logic         is_write;
      outcome  = '0;
      is_write = (kind == REQ_WR_FIELD || kind == REQ_WR_BIT);
      width    = (kind == REQ_WR_FIELD || kind == REQ_RD_FIELD) ? field_bits(field_limit) : 1;
      pos      = is_write ? wr_pos : rd_pos;
      if (pos + width > STORE_BYTES * BYTE_BITS) begin
         outcome.status = 1'b1;
      end else begin
         for (int i = 0; i < width; i++) begin
            p = pos + i;
            if (is_write) begin
               byte_mem[p / BYTE_BITS][BIT_IDX_MAX - p % BYTE_BITS] = value[width - 1 - i];
            end else begin
               outcome.read_value = {outcome.read_value[14:0],
                                     byte_mem[p / BYTE_BITS][BIT_IDX_MAX - p % BYTE_BITS]};
            end
         end
         if (is_write) begin
            wr_pos = pos + width;
         end else begin
            rd_pos = pos + width;
         end
      end
      return outcome;
   endfunction

   always @(posedge clock) begin : track
      rsp_word_type want;
      if (reset) begin
         for (int i = 0; i < STORE_BYTES; i++) byte_mem[i] = '0;
         wr_pos      = 0;
         rd_pos      = 0;
         field_limit = 16'd1;
         errors      = 0;
         due_responses.delete();
      end else begin
         if (csr_wr_en === 1'b1) field_limit = csr_wr_data;
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (due_responses.size() == 0) begin
               $error("response word with no request waiting: read_value %h status %b",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = due_responses.pop_front();
               if (rsp_tdata !== want.read_value) begin
                  $error("read_value mismatch: expected %h, actual %h",
                         want.read_value, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser[0] !== want.status) begin
                  $error("status mismatch: expected %b, actual %b", want.status, rsp_tuser);
                  errors++;
               end
            end
         end
         if (req_tvalid === 1'b1 && req_tready === 1'b1) begin
            due_responses.push_back(apply_request(req_kind_type'(req_tuser), req_tdata));
         end
      end
      fail_count <= errors;
      pending    <= due_responses.size();
   end

endmodule

FILE: test/tb_bit_field_packer_unpacker.sv
`timescale 1ns / 1ps
// Testbench top with clock, reset, request and response traffic, and the verdict.
module tb_bit_field_packer_unpacker;
   import bfp_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned LONG_HOLD   = 400;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   int          fail_count;
   int          pending;
   bit          sender_calm = 1'b0;

   bit_field_packer_unpacker uut (.*);

   bfp_response_checker response_check (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic send_request(input req_kind_type kind, input logic [15:0] value);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_field_limit(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_kind_type draw_kind(input int wr_field, input int wr_bit,
                                              input int rd_field);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < wr_field) return REQ_WR_FIELD;
      if (roll < wr_field + wr_bit) return REQ_WR_BIT;
      if (roll < wr_field + wr_bit + rd_field) return REQ_RD_FIELD;
      return REQ_RD_BIT;
   endfunction

   task automatic run_requests(input int count, input int wr_field, input int wr_bit,
                               input int rd_field, input bit pause_midway);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
         if (pause_midway && n == count / 2) drain_responses();
         send_request(draw_kind(wr_field, wr_bit, rd_field), 16'($urandom_range(0, 65535)));
      end
   endtask

   initial begin : receiver
      int gap;
      int served;
      bit calm;
      served = 0;
      calm   = 1'b0;
      forever begin
         if (served % 64 == 0) calm = ($urandom_range(0, 3) == 0);
         gap = calm ? 0 : $urandom_range(0, 8);
         if (served == 300 || served == 1300) gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         served++;
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] limit;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reads before any write see a cleared store.
      send_request(REQ_RD_FIELD, 16'hFFFF);
      send_request(REQ_RD_BIT, 16'h0000);
      drain_responses();

      // Full-width fields from an odd bit offset straddle three bytes.
      set_field_limit(16'hFFFF);
      send_request(REQ_WR_BIT, 16'h0001);
      send_request(REQ_WR_FIELD, 16'hFFFF);
      send_request(REQ_WR_FIELD, 16'h0000);
      send_request(REQ_WR_FIELD, 16'hA5C3);
      send_request(REQ_WR_BIT, 16'hFFFE);
      send_request(REQ_RD_BIT, 16'h0000);
      send_request(REQ_RD_FIELD, 16'h0000);
      send_request(REQ_RD_FIELD, 16'hFFFF);
      send_request(REQ_RD_FIELD, 16'h0000);
      send_request(REQ_RD_BIT, 16'h0000);
      send_request(REQ_RD_FIELD, 16'h0000);
      drain_responses();

      // A zero maximum still gives a one-bit field, and values are masked.
      set_field_limit(16'h0000);
      send_request(REQ_WR_FIELD, 16'hFFFE);
      send_request(REQ_RD_FIELD, 16'h0000);
      drain_responses();
      set_field_limit(16'd5);
      send_request(REQ_WR_FIELD, 16'hFFFF);
      send_request(REQ_RD_FIELD, 16'h0000);
      send_request(REQ_WR_FIELD, 16'h0002);

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: limit = 16'd1;
            1: limit = 16'hFFFF;
            2: limit = 16'h0000;
            3: limit = 16'h8000;
            4: limit = 16'($urandom_range(2, 255));
            default: limit = 16'($urandom_range(1, 65535));
         endcase
         drain_responses();
         set_field_limit(limit);
         run_requests(120, 35, 15, 35, ph == 3);
      end

      // Run both cursors into the end of the store.
      drain_responses();
      set_field_limit(16'hFFFF);
      run_requests(1000, 45, 10, 40, 1'b0);

      drain_responses();
      set_field_limit(16'd1);
      run_requests(60, 25, 25, 25, 1'b0);

      drain_responses();
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
